/* src/bpa_pkg.sv */
package bpa_pkg;

	// Item kinds as they arrive on the input channel
	typedef enum logic [1:0] {
		KIND_INIT  = 2'd0,
		KIND_ALLOC = 2'd1,
		KIND_FREE  = 2'd2,
		KIND_BAD   = 2'd3
	} kind_t;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_REGION_START = 1'b0,
		CFG_REGION_SIZE  = 1'b1
	} cfg_idx_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_SWEEP,
		ST_SCAN,
		ST_RD,
		ST_WR,
		ST_DONE
	} state_t;

	// Datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_SETUP,
		OP_SWEEP,
		OP_SCAN,
		OP_RD,
		OP_WR,
		OP_PUSH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  skip;
		logic  hit;
		logic  fail;
		logic  wlast;
		logic  out_free;
	} stat_t;

endpackage

/* src/bpa_ctrl.sv */
module bpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output bpa_pkg::cmd_t  cmd,
	input  bpa_pkg::stat_t stat
);

	bpa_pkg::state_t state_q, state_n;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			bpa_pkg::ST_CLEAR: begin
				if (stat.wlast) state_n = bpa_pkg::ST_IDLE;
			end
			bpa_pkg::ST_IDLE: begin
				if (in_valid) state_n = bpa_pkg::ST_SETUP;
			end
			bpa_pkg::ST_SETUP: begin
				unique case (stat.kind)
					bpa_pkg::KIND_INIT:  state_n = bpa_pkg::ST_SWEEP;
					bpa_pkg::KIND_ALLOC: state_n = stat.skip ? bpa_pkg::ST_DONE
					                                         : bpa_pkg::ST_SCAN;
					bpa_pkg::KIND_FREE:  state_n = stat.skip ? bpa_pkg::ST_DONE
					                                         : bpa_pkg::ST_RD;
					default:             state_n = bpa_pkg::ST_DONE;
				endcase
			end
			bpa_pkg::ST_SWEEP: begin
				if (stat.wlast) state_n = bpa_pkg::ST_DONE;
			end
			bpa_pkg::ST_SCAN: begin
				if (stat.hit) state_n = bpa_pkg::ST_RD;
				else if (stat.fail) state_n = bpa_pkg::ST_DONE;
			end
			bpa_pkg::ST_RD: begin
				state_n = bpa_pkg::ST_WR;
			end
			bpa_pkg::ST_WR: begin
				state_n = stat.wlast ? bpa_pkg::ST_DONE : bpa_pkg::ST_RD;
			end
			bpa_pkg::ST_DONE: begin
				if (stat.out_free) state_n = bpa_pkg::ST_IDLE;
			end
			default: state_n = bpa_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready = 1'b0;
		cmd.op   = bpa_pkg::OP_NONE;
		unique case (state_q)
			bpa_pkg::ST_CLEAR: cmd.op = bpa_pkg::OP_SWEEP;
			bpa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = bpa_pkg::OP_LOAD;
			end
			bpa_pkg::ST_SETUP: cmd.op = bpa_pkg::OP_SETUP;
			bpa_pkg::ST_SWEEP: cmd.op = bpa_pkg::OP_SWEEP;
			bpa_pkg::ST_SCAN:  cmd.op = bpa_pkg::OP_SCAN;
			bpa_pkg::ST_RD:    cmd.op = bpa_pkg::OP_RD;
			bpa_pkg::ST_WR:    cmd.op = bpa_pkg::OP_WR;
			bpa_pkg::ST_DONE: begin
				if (stat.out_free) cmd.op = bpa_pkg::OP_PUSH;
			end
			default: cmd.op = bpa_pkg::OP_NONE;
		endcase
	end

endmodule

/* src/bpa_dp.sv */
module bpa_dp #(
	parameter int MAX_PAGES  = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bpa_pkg::cmd_t  cmd,
	output bpa_pkg::stat_t stat,
	input  logic [1:0]     kind,
	input  logic [31:0]    page_addr,
	input  logic [10:0]    page_count,
	input  logic [31:0]    region_start,
	input  logic [31:0]    region_size,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    result_addr,
	output logic           success,
	output logic [10:0]    pages_released,
	output logic [10:0]    used_count,
	output logic [10:0]    free_count,
	output logic [10:0]    total_count
);

	localparam int W   = (MAX_PAGES >= 32) ? 32 : 8;
	localparam int WB  = $clog2(W);
	localparam int NW  = (MAX_PAGES + W - 1) / W;
	localparam int IW  = (NW > 1) ? $clog2(NW) : 1;
	localparam int CW0 = $clog2(MAX_PAGES + W) + 1;
	localparam int CW  = (CW0 > 12) ? CW0 : 12;
	localparam int SH  = $clog2(PAGE_BYTES);
	localparam int AW  = 32 - SH;

	// Page map, one word of W pages per entry
	logic [W-1:0] mem [NW];
	logic [W-1:0] rdata_s1;

	// Control state
	logic [IW-1:0] wptr_q, rptr_q, last_q, eidx_s1;
	logic          ev_s1;
	logic [CW-1:0] lo_q, hi_q, hi2_q;
	logic [31:0]   base_q;
	logic [CW-1:0] managed_q, used_q;
	logic          out_valid_q;

	// Item payload
	bpa_pkg::kind_t kind_q;
	logic [31:0]    off_q;
	logic [10:0]    cnt_q;
	logic [CW-1:0]  run_q, rel_q;
	logic [31:0]    res_addr_q;
	logic           success_q;

	// Result register
	logic [31:0] o_addr_q;
	logic        o_ok_q;
	logic [10:0] o_rel_q, o_used_q, o_free_q, o_total_q;

	logic [CW-1:0] cnt_ext;
	assign cnt_ext = CW'(cnt_q);

	// Mask of the current write word against the active page ranges
	logic [CW-1:0] widx [W];
	logic [W-1:0]  mask_w;
	always_comb begin
		for (int b = 0; b < W; b++) begin
			widx[b]   = (CW'(wptr_q) << WB) + CW'(b);
			mask_w[b] = ((widx[b] >= lo_q) && (widx[b] < hi_q)) || (widx[b] < hi2_q);
		end
	end

	// Scan one word: run length ending at each bit, lowest bit that completes the run
	logic [CW-1:0] sidx  [W];
	logic [CW-1:0] run_v [W];
	logic [WB-1:0] lastp [W];
	logic [W-1:0]  used_v, have_v, hitv;
	logic [WB-1:0] hb;
	always_comb begin
		for (int b = 0; b < W; b++) begin
			sidx[b]   = (CW'(eidx_s1) << WB) + CW'(b);
			used_v[b] = rdata_s1[b] | (sidx[b] >= managed_q);
		end
		for (int b = 0; b < W; b++) begin
			have_v[b] = 1'b0;
			lastp[b]  = '0;
			for (int j = 0; j < W; j++) begin
				if (j <= b && used_v[j]) begin
					have_v[b] = 1'b1;
					lastp[b]  = WB'(j);
				end
			end
			run_v[b] = have_v[b] ? (CW'(b) - CW'(lastp[b])) : (run_q + CW'(b) + CW'(1));
			hitv[b]  = !used_v[b] && (run_v[b] >= cnt_ext);
		end
		hb = '0;
		for (int b = W - 1; b >= 0; b--) begin
			if (hitv[b]) hb = WB'(b);
		end
	end

	logic          scan_hit, scan_fail;
	logic [CW-1:0] hend, hs;
	assign scan_hit  = ev_s1 && (|hitv);
	assign scan_fail = ev_s1 && !(|hitv) && (eidx_s1 == last_q);
	assign hend      = (CW'(eidx_s1) << WB) + CW'(hb);
	assign hs        = hend + CW'(1) - cnt_ext;

	// Init setup: rounded base, page total, pages taken by the map itself
	logic [32:0]   up;
	logic [31:0]   pages_raw, mb, res;
	logic [CW-1:0] pages_c, resv;
	always_comb begin
		up        = ({1'b0, region_start} + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1);
		pages_raw = region_size >> SH;
		pages_c   = (pages_raw > 32'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(pages_raw);
		mb        = (32'(pages_c) + 32'd7) >> 3;
		res       = (mb + 32'(PAGE_BYTES - 1)) >> SH;
		resv      = (res < 32'(pages_c)) ? CW'(res) : pages_c;
	end

	// Free setup: first page index and the two segments the run may cover
	logic          aligned, seg_ok, wrap;
	logic [32:0]   i0, e0, e2;
	logic [CW-1:0] hia, hi2_n;
	always_comb begin
		aligned = (off_q[SH-1:0] == '0);
		i0      = {1'b0, off_q} >> SH;
		e0      = i0 + 33'(cnt_q);
		seg_ok  = i0 < 33'(managed_q);
		hia     = (e0 < 33'(managed_q)) ? CW'(e0) : managed_q;
		wrap    = e0 > (33'(1) << AW);
		e2      = e0 - (33'(1) << AW);
		hi2_n   = !wrap ? '0 : ((e2 < 33'(managed_q)) ? CW'(e2) : managed_q);
	end

	logic [IW-1:0] last_m;
	assign last_m = IW'((managed_q - CW'(1)) >> WB);

	// Write data and released pages in the current word
	logic [W-1:0]  wdata, relw;
	logic [CW-1:0] rel_w;
	always_comb begin
		relw  = rdata_s1 & mask_w;
		rel_w = '0;
		for (int b = 0; b < W; b++) begin
			rel_w = rel_w + CW'(relw[b]);
		end
		if (cmd.op == bpa_pkg::OP_SWEEP) wdata = mask_w;
		else if (kind_q == bpa_pkg::KIND_ALLOC) wdata = rdata_s1 | mask_w;
		else wdata = rdata_s1 & ~mask_w;
	end

	logic [CW-1:0] used_n, free_n;
	always_comb begin
		used_n = used_q;
		if (kind_q == bpa_pkg::KIND_FREE) used_n = (used_q > rel_q) ? (used_q - rel_q) : '0;
		free_n = (managed_q > used_n) ? (managed_q - used_n) : '0;
	end

	// Status to controller
	always_comb begin
		stat.kind     = kind_q;
		stat.hit      = scan_hit;
		stat.fail     = scan_fail;
		stat.wlast    = (wptr_q == last_q);
		stat.out_free = !out_valid_q || out_ready;
		case (kind_q)
			bpa_pkg::KIND_ALLOC: stat.skip = (cnt_q == '0) || (managed_q == '0);
			bpa_pkg::KIND_FREE:  stat.skip = !aligned || (managed_q == '0);
			bpa_pkg::KIND_INIT:  stat.skip = 1'b0;
			default:             stat.skip = 1'b1;
		endcase
	end

	// Page map memory: written on sweep and write steps, registered read on scan and read steps
	always_ff @(posedge clk) begin
		if (cmd.op == bpa_pkg::OP_SWEEP || cmd.op == bpa_pkg::OP_WR) mem[wptr_q] <= wdata;
		if (cmd.op == bpa_pkg::OP_SCAN) rdata_s1 <= mem[rptr_q];
		else if (cmd.op == bpa_pkg::OP_RD) rdata_s1 <= mem[wptr_q];
	end

	// Control and counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q      <= '0;
			rptr_q      <= '0;
			last_q      <= IW'(NW - 1);
			ev_s1       <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			hi2_q       <= '0;
			base_q      <= '0;
			managed_q   <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				bpa_pkg::OP_SETUP: begin
					case (kind_q)
						bpa_pkg::KIND_INIT: begin
							base_q    <= up[31:0];
							managed_q <= pages_c;
							used_q    <= resv;
							lo_q      <= '0;
							hi_q      <= resv;
							hi2_q     <= '0;
							wptr_q    <= '0;
							last_q    <= IW'(NW - 1);
						end
						bpa_pkg::KIND_ALLOC: begin
							rptr_q <= '0;
							ev_s1  <= 1'b0;
							last_q <= last_m;
						end
						bpa_pkg::KIND_FREE: begin
							wptr_q <= '0;
							last_q <= last_m;
							lo_q   <= seg_ok ? CW'(i0) : '0;
							hi_q   <= seg_ok ? hia : '0;
							hi2_q  <= hi2_n;
						end
						default: ;
					endcase
				end
				bpa_pkg::OP_SWEEP: wptr_q <= wptr_q + IW'(1);
				bpa_pkg::OP_SCAN: begin
					rptr_q <= rptr_q + IW'(1);
					ev_s1  <= 1'b1;
					if (scan_hit) begin
						lo_q   <= hs;
						hi_q   <= hend + CW'(1);
						hi2_q  <= '0;
						wptr_q <= IW'(hs >> WB);
						last_q <= IW'(hend >> WB);
						used_q <= used_q + cnt_ext;
					end
				end
				bpa_pkg::OP_WR: wptr_q <= wptr_q + IW'(1);
				bpa_pkg::OP_PUSH: used_q <= used_n;
				default: ;
			endcase
			// Hold the result until it is taken
			if (cmd.op == bpa_pkg::OP_PUSH) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Item payload and result registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			bpa_pkg::OP_LOAD: begin
				kind_q     <= bpa_pkg::kind_t'(kind);
				cnt_q      <= page_count;
				off_q      <= page_addr - base_q;
				rel_q      <= '0;
				res_addr_q <= '0;
				success_q  <= 1'b0;
			end
			bpa_pkg::OP_SETUP: begin
				run_q     <= '0;
				success_q <= (kind_q == bpa_pkg::KIND_INIT) || (kind_q == bpa_pkg::KIND_FREE);
			end
			bpa_pkg::OP_SCAN: begin
				eidx_s1 <= rptr_q;
				if (scan_hit) begin
					res_addr_q <= base_q + (32'(hs) << SH);
					success_q  <= 1'b1;
				end else if (ev_s1) begin
					run_q <= run_v[W-1];
				end
			end
			bpa_pkg::OP_WR: begin
				if (kind_q == bpa_pkg::KIND_FREE) rel_q <= rel_q + rel_w;
			end
			bpa_pkg::OP_PUSH: begin
				o_addr_q  <= res_addr_q;
				o_ok_q    <= success_q;
				o_rel_q   <= rel_q[10:0];
				o_used_q  <= used_n[10:0];
				o_free_q  <= free_n[10:0];
				o_total_q <= managed_q[10:0];
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign result_addr    = o_addr_q;
	assign success        = o_ok_q;
	assign pages_released = o_rel_q;
	assign used_count     = o_used_q;
	assign free_count     = o_free_q;
	assign total_count    = o_total_q;

	a_used_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= managed_q)
		else $error("used pages exceed managed pages");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == bpa_pkg::OP_WR) |-> (wptr_q <= last_q))
		else $error("map write beyond last word of the run");

	a_alloc_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == bpa_pkg::OP_PUSH && kind_q == bpa_pkg::KIND_ALLOC && success_q)
		|-> ((hi_q - lo_q) == cnt_ext))
		else $error("allocated run length differs from request");

endmodule

/* src/bitmap_page_allocator.sv */
// First-fit bitmap page allocator. Items: init (take region from config),
// alloc (lowest free run), free (release aligned, in-range, used pages).
// One item is in work at a time; the page map is a memory of 32-page words
// (8-page words when MAX_PAGES is below 32) with one port access per cycle,
// which sets the timing. Init is one sweep writing every word. Alloc scans
// a word per cycle, then marks the run with a read-modify-write per word
// covered. Free does a read-modify-write of every word of the managed map.
// After reset a clearing pass over every word runs before the first item is
// taken. PAGE_BYTES must be a power of two. Configuration must be written by
// the user only while no item is in work; the block does not enforce this.
module bitmap_page_allocator #(
	parameter int MAX_PAGES  = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] page_addr,
	input  logic [10:0] page_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_addr,
	output logic        success,
	output logic [10:0] pages_released,
	output logic [10:0] used_count,
	output logic [10:0] free_count,
	output logic [10:0] total_count
);

	logic [31:0]    region_start_q, region_size_q;
	bpa_pkg::cmd_t  cmd;
	bpa_pkg::stat_t stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= '0;
			region_size_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (bpa_pkg::cfg_idx_t'(cfg_index))
				bpa_pkg::CFG_REGION_START: region_start_q <= cfg_wdata;
				bpa_pkg::CFG_REGION_SIZE:  region_size_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	bpa_dp #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.kind           (kind),
		.page_addr      (page_addr),
		.page_count     (page_count),
		.region_start   (region_start_q),
		.region_size    (region_size_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_addr    (result_addr),
		.success        (success),
		.pages_released (pages_released),
		.used_count     (used_count),
		.free_count     (free_count),
		.total_count    (total_count)
	);

endmodule
